### src/rrlu_pkg.sv
// Shared types and constants for the register rename / last-use block.
package rrlu_pkg;

    localparam int NAME_W    = 14;
    localparam int POS_W     = 12;
    localparam int OP_W      = 4;
    localparam int REG_W     = 8;
    localparam int LEN_W     = 13;
    localparam int MAX_REGS  = 256;
    localparam int MAX_BLOCK = 4096;
    localparam logic [NAME_W-1:0] NAME_MAX = 14'd16383;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 4'd0,
        OP_STORE  = 4'd1,
        OP_LOADI  = 4'd2,
        OP_ADD    = 4'd3,
        OP_SUB    = 4'd4,
        OP_MULT   = 4'd5,
        OP_LSHIFT = 4'd6,
        OP_RSHIFT = 4'd7,
        OP_OUTPUT = 4'd8,
        OP_NOP    = 4'd9
    } opcode_t;

    // sequencer steps of the back end
    typedef enum logic [2:0] {ST_IDLE, ST_DEF, ST_U1, ST_U2, ST_U3, ST_DONE} bstate_t;

    // classified instruction handed from front to back
    typedef struct packed {
        logic              start;
        logic [OP_W-1:0]   op;
        logic              def3;
        logic              use1;
        logic              use2;
        logic              use3;
        logic [REG_W-1:0]  r1;
        logic [REG_W-1:0]  r2;
        logic [REG_W-1:0]  r3;
    } instr_t;

    typedef struct packed {
        logic [NAME_W-1:0] vr;
        logic [POS_W-1:0]  nu;
        logic              has;
    } opnd_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        opnd_t             o1;
        opnd_t             o2;
        opnd_t             o3;
        logic [NAME_W-1:0] names;
    } result_t;

endpackage

### src/register_rename_last_use_core.sv
// Top level of the register rename / last-use block.
// Instructions of a basic block enter on the s_ stream, last instruction first,
// with tuser carrying start_block on the first item of each block. Each
// non-nop instruction yields one transfer on the m_ stream with virtual names
// and next-use positions of its operands; nops yield nothing.
// A two-entry queue decouples the input from the table sequencer.
// The sequencer takes an instruction from the queue, steps through its table
// operands (none to three), one access each, and then posts the result; the steps
// are set by the single read-modify-write port on the rename table. A nop is
// taken from the queue and yields no steps. The sequencer takes no new instruction
// until it has posted the current result and the output is free.
// block_length is written over APB at address 0; the user must write it only
// while the block is idle, which the block itself does not enforce. Reset clears
// the queue, the valid bits, the name counter and position, and sets block_length to 1.
// If m_tready is low the result is held; the queue keeps taking input
// until full.
module register_rename_last_use_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[3:0], src1_reg[11:4], src2_reg[19:12], third_reg[27:20], zero[31:28]
    input  logic [31:0]  s_tdata,
    input  logic         s_tuser,   // start_block
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // op_out, position, first_vr, first_next_use, first_has_next,
                                    // second_vr, second_next_use, second_has_next, third_vr,
                                    // third_next_use, third_has_next, names_used, zero
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rrlu_pkg::*;

    logic [12:0] len_reg;
    logic        q_valid, q_ready;
    instr_t      q_data;
    result_t     r;

    assign pready = 1'b1;
    assign prdata = {19'd0, len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) len_reg <= 13'd1;
        else if (psel && penable && pwrite && !paddr) len_reg <= pwdata[12:0];
    end

    rrlu_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_start(s_tuser), .s_op(s_tdata[3:0]), .s_r1(s_tdata[11:4]), .s_r2(s_tdata[19:12]),
        .s_r3(s_tdata[27:20]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    rrlu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .block_length(len_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(r)
    );

    assign m_tdata = {1'b0, r.names, r.o3.has, r.o3.nu, r.o3.vr, r.o2.has, r.o2.nu, r.o2.vr,
                      r.o1.has, r.o1.nu, r.o1.vr, r.pos, r.op};

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_nop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] != OP_NOP)
        else $error("nop produced a result");
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

### src/rrlu_front.sv
// Front end: accept instructions, decode operand roles, two-entry queue.
module rrlu_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            s_start,
    input  logic [3:0]      s_op,
    input  logic [7:0]      s_r1,
    input  logic [7:0]      s_r2,
    input  logic [7:0]      s_r3,
    output logic            q_valid,
    input  logic            q_ready,
    output rrlu_pkg::instr_t q_data
);
    import rrlu_pkg::*;

    instr_t     ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    instr_t     dec;
    logic       push, pop;

    always_comb begin
        dec = '0;
        dec.start = s_start;
        dec.op = s_op;
        dec.r1 = s_r1;
        dec.r2 = s_r2;
        dec.r3 = s_r3;
        unique case (s_op)
            OP_LOAD:   begin dec.def3 = 1'b1; dec.use1 = 1'b1; end
            OP_STORE:  begin dec.use1 = 1'b1; dec.use3 = 1'b1; end
            OP_LOADI:  dec.def3 = 1'b1;
            OP_OUTPUT, OP_NOP: ;
            default:   begin dec.def3 = 1'b1; dec.use1 = 1'b1; dec.use2 = 1'b1; end
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_data = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) ent_reg[wr_ptr_reg] <= dec;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### src/rrlu_back.sv
// Back end: sequence table accesses per operand and build the result.
module rrlu_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [12:0]             block_length,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  rrlu_pkg::instr_t        q_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rrlu_pkg::result_t       m_data
);
    import rrlu_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGS);

    logic [NAME_W-1:0] name_mem [MAX_REGS];
    logic [POS_W-1:0]  pos_mem  [MAX_REGS];
    logic [MAX_REGS-1:0] mval_reg, uval_reg;
    logic [NAME_W-1:0] fresh_reg;
    logic [POS_W-1:0]  cur_reg;
    bstate_t           st_reg, st_next;
    instr_t            ins_reg;
    result_t           res_reg, res_next;
    logic              out_v_reg;
    logic [NAME_W-1:0] name_rd_reg;
    logic [POS_W-1:0]  pos_rd_reg;

    logic [IDX_W-1:0]  idx, idx_next;
    instr_t            nxt_ins;
    logic              mv, uv;
    opnd_t             acc;
    logic [12:0]       len_c;
    logic              is_def, active, take;

    // selected register for the current step
    always_comb begin
        idx = '0;
        unique case (st_reg)
            ST_DEF:  idx = ins_reg.r3[IDX_W-1:0];
            ST_U1:   idx = ins_reg.r1[IDX_W-1:0];
            ST_U2:   idx = ins_reg.r2[IDX_W-1:0];
            ST_U3:   idx = ins_reg.r3[IDX_W-1:0];
            default: idx = '0;
        endcase
    end

    // register read for the following step
    assign nxt_ins = (st_reg == ST_IDLE) ? q_data : ins_reg;

    always_comb begin
        idx_next = '0;
        unique case (st_next)
            ST_DEF:  idx_next = nxt_ins.r3[IDX_W-1:0];
            ST_U1:   idx_next = nxt_ins.r1[IDX_W-1:0];
            ST_U2:   idx_next = nxt_ins.r2[IDX_W-1:0];
            ST_U3:   idx_next = nxt_ins.r3[IDX_W-1:0];
            default: idx_next = '0;
        endcase
    end

    assign mv = mval_reg[idx];
    assign uv = uval_reg[idx];
    assign acc.vr  = mv ? name_rd_reg : fresh_reg;
    assign acc.has = uv;
    assign acc.nu  = uv ? pos_rd_reg : '0;
    assign is_def = (st_reg == ST_DEF);
    assign active = (st_reg == ST_DEF) || (st_reg == ST_U1) || (st_reg == ST_U2)
                    || (st_reg == ST_U3);
    assign take = q_valid && q_ready;

    always_comb begin
        len_c = block_length;
        if (len_c == 13'd0) len_c = 13'd1;
        if (32'(len_c) > MAX_BLOCK) len_c = 13'(MAX_BLOCK);
    end

    // next operand after the current one
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (q_valid && (!out_v_reg || m_ready)) begin
                if (q_data.op == OP_NOP) st_next = ST_IDLE;
                else if (q_data.def3) st_next = ST_DEF;
                else if (q_data.use1) st_next = ST_U1;
                else st_next = ST_DONE;
            end
            ST_DEF:  st_next = ins_reg.use1 ? ST_U1 : ST_DONE;
            ST_U1:   st_next = ins_reg.use2 ? ST_U2 : (ins_reg.use3 ? ST_U3 : ST_DONE);
            ST_U2:   st_next = ST_DONE;
            ST_U3:   st_next = ST_DONE;
            ST_DONE: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    assign q_ready = (st_reg == ST_IDLE) && (!out_v_reg || m_ready);
    assign m_valid = out_v_reg;
    assign m_data  = res_reg;

    always_comb begin
        res_next = res_reg;
        if (take) begin
            res_next = '0;
            res_next.op = q_data.op;
            res_next.pos = q_data.start ? 12'(len_c - 13'd1) : cur_reg;
        end
        unique case (st_reg)
            ST_DEF:  res_next.o3 = acc;
            ST_U1:   res_next.o1 = acc;
            ST_U2:   res_next.o2 = acc;
            ST_U3:   res_next.o3 = acc;
            ST_DONE: res_next.names = fresh_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (active && !mv) name_mem[idx] <= fresh_reg;
        if (active && !is_def) pos_mem[idx] <= cur_reg;
        // forward a write that lands on the entry read for the next step
        if (active && !mv && idx == idx_next) name_rd_reg <= fresh_reg;
        else name_rd_reg <= name_mem[idx_next];
        if (active && !is_def && idx == idx_next) pos_rd_reg <= cur_reg;
        else pos_rd_reg <= pos_mem[idx_next];
        if (take) ins_reg <= q_data;
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            mval_reg <= '0;
            uval_reg <= '0;
            fresh_reg <= '0;
            cur_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            if (take && q_data.start) begin
                mval_reg <= '0;
                uval_reg <= '0;
                fresh_reg <= '0;
                cur_reg <= 12'(len_c - 13'd1);
            end
            if (active) begin
                if (!mv && fresh_reg != NAME_MAX) fresh_reg <= fresh_reg + 1'b1;
                mval_reg[idx] <= !is_def;
                uval_reg[idx] <= !is_def;
            end
            if (st_reg == ST_DONE) begin
                out_v_reg <= 1'b1;
                if (cur_reg != '0) cur_reg <= cur_reg - 1'b1;
            end
        end
    end
endmodule

### tb/tb_register_rename_last_use_core.sv
// Self-checking testbench for the register rename / last-use core.
`timescale 1ns / 1ps

module tb_register_rename_last_use_core;
    import rrlu_pkg::*;

    localparam int NUM_REGS   = 256;
    localparam int BLOCK_MAX  = 4096;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 20;
    localparam int MAX_SHOWN  = 40;

    typedef struct {
        logic             start;
        logic [OP_W-1:0]  op;
        logic [REG_W-1:0] r1;
        logic [REG_W-1:0] r2;
        logic [REG_W-1:0] r3;
    } instr_item_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_word;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic         paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    instr_item_t pending_instrs[$];
    instr_item_t drive_item;
    result_t     expected_results[$];

    // model of the rename tables
    logic [NAME_W-1:0] rn_name[NUM_REGS];
    bit                rn_mapped[NUM_REGS];
    logic [POS_W-1:0]  rn_next[NUM_REGS];
    bit                rn_has_next[NUM_REGS];
    logic [NAME_W-1:0] rn_fresh;
    logic [POS_W-1:0]  rn_pos;
    logic [LEN_W-1:0]  rn_block_len;

    int send_idle;
    int recv_idle;
    int errors;
    int results_seen;
    int instrs_sent;
    int quiet_cycles;

    register_rename_last_use_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_word),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // opcode[3:0], src1_reg[11:4], src2_reg[19:12], third_reg[27:20]
    assign s_word  = {4'd0, drive_item.r3, drive_item.r2, drive_item.r1, drive_item.op};
    assign s_tuser = drive_item.start;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [NAME_W-1:0] take_name(input int r);
        if (!rn_mapped[r]) begin
            rn_name[r]   = rn_fresh;
            rn_mapped[r] = 1'b1;
            if (rn_fresh < NAME_MAX) rn_fresh++;
        end
        return rn_name[r];
    endfunction

    function automatic opnd_t rename_def(input logic [REG_W-1:0] reg_no);
        opnd_t o;
        int r;
        r = reg_no % NUM_REGS;
        o.vr  = take_name(r);
        o.has = rn_has_next[r];
        o.nu  = rn_has_next[r] ? rn_next[r] : '0;
        rn_mapped[r]   = 1'b0;
        rn_has_next[r] = 1'b0;
        return o;
    endfunction

    function automatic opnd_t rename_use(input logic [REG_W-1:0] reg_no);
        opnd_t o;
        int r;
        r = reg_no % NUM_REGS;
        o.vr  = take_name(r);
        o.has = rn_has_next[r];
        o.nu  = rn_has_next[r] ? rn_next[r] : '0;
        rn_next[r]     = rn_pos;
        rn_has_next[r] = 1'b1;
        return o;
    endfunction

    task automatic rename_instr(input instr_item_t it);
        result_t res;
        int len;
        if (it.start) begin
            len = rn_block_len;
            if (len < 1) len = 1;
            if (len > BLOCK_MAX) len = BLOCK_MAX;
            for (int i = 0; i < NUM_REGS; i++) begin
                rn_mapped[i]   = 1'b0;
                rn_has_next[i] = 1'b0;
            end
            rn_fresh = '0;
            rn_pos   = POS_W'(len - 1);
        end
        if (it.op == OP_NOP) return;
        res     = '0;
        res.op  = it.op;
        res.pos = rn_pos;
        case (it.op)
            OP_LOAD: begin
                res.o3 = rename_def(it.r3);
                res.o1 = rename_use(it.r1);
            end
            OP_STORE: begin
                res.o1 = rename_use(it.r1);
                res.o3 = rename_use(it.r3);
            end
            OP_LOADI: res.o3 = rename_def(it.r3);
            OP_OUTPUT: ;
            default: begin
                res.o3 = rename_def(it.r3);
                res.o1 = rename_use(it.r1);
                res.o2 = rename_use(it.r2);
            end
        endcase
        res.names = rn_fresh;
        if (rn_pos > 0) rn_pos--;
        expected_results.insert(expected_results.size(), res);
    endtask

    function automatic result_t unpack_result(input logic [111:0] d);
        result_t r;
        r.op     = d[3:0];
        r.pos    = d[15:4];
        r.o1.vr  = d[29:16];
        r.o1.nu  = d[41:30];
        r.o1.has = d[42];
        r.o2.vr  = d[56:43];
        r.o2.nu  = d[68:57];
        r.o2.has = d[69];
        r.o3.vr  = d[83:70];
        r.o3.nu  = d[95:84];
        r.o3.has = d[96];
        r.names  = d[110:97];
        return r;
    endfunction

    function automatic void split_fields(input result_t r, output int f[12]);
        f = '{r.op, r.pos, r.o1.vr, r.o1.nu, r.o1.has, r.o2.vr, r.o2.nu, r.o2.has,
              r.o3.vr, r.o3.nu, r.o3.has, r.names};
    endfunction

    // driver: advance to the next pending instruction once the current one transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_instrs.size() > 0 && $urandom_range(99) >= send_idle) begin
                drive_item <= pending_instrs.pop_front();
                s_tvalid   <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor: predict on input transfers, check on result transfers
    always @(posedge aclk) begin
        int ef[12];
        int af[12];
        string fname[12];
        fname = '{"op_out", "position", "first_vr", "first_next_use", "first_has_next",
                  "second_vr", "second_next_use", "second_has_next", "third_vr",
                  "third_next_use", "third_has_next", "names_used"};
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rename_instr(drive_item);
                instrs_sent++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("%0t: unexpected result, expected none, actual %h",
                                 $time, m_tdata);
                end else begin
                    split_fields(expected_results.pop_front(), ef);
                    split_fields(unpack_result(m_tdata), af);
                    for (int i = 0; i < 12; i++) begin
                        if (ef[i] != af[i]) begin
                            errors++;
                            if (errors <= MAX_SHOWN)
                                $display("%0t: %s mismatch, expected %0d, actual %0d",
                                         $time, fname[i], ef[i], af[i]);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_instr(input logic start, input logic [OP_W-1:0] op,
                              input logic [REG_W-1:0] r1, input logic [REG_W-1:0] r2,
                              input logic [REG_W-1:0] r3);
        instr_item_t it;
        it.start = start;
        it.op    = op;
        it.r1    = r1;
        it.r2    = r2;
        it.r3    = r3;
        pending_instrs.insert(pending_instrs.size(), it);
    endtask

    task automatic drain();
        while (pending_instrs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_block_len(input logic [LEN_W-1:0] len);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 1'b0;
        pwdata  <= 32'(len);
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rn_block_len = len;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [REG_W-1:0] pick_reg(input bit wide, input int base,
                                                   input int span);
        if (wide) return REG_W'($urandom_range(255));
        return REG_W'(base + $urandom_range(span - 1));
    endfunction

    function automatic logic [OP_W-1:0] OP_OPW_RAND();
        return OP_W'($urandom_range(15, 10));
    endfunction

    // well-formed blocks with random content, some broken or noisy ones
    task automatic random_blocks(input int count);
        int made;
        int eff;
        int size;
        int base;
        int span;
        bit wide;
        logic [OP_W-1:0] op;
        made = 0;
        eff  = (rn_block_len < 1) ? 1 : (rn_block_len > BLOCK_MAX) ? BLOCK_MAX : rn_block_len;
        while (made < count) begin
            size = (eff > 60) ? $urandom_range(60, 10) : eff;
            if ($urandom_range(9) == 0) size = $urandom_range(eff + 5, 1);
            wide = ($urandom_range(3) == 0);
            base = $urandom_range(240);
            span = $urandom_range(12, 3);
            for (int k = 0; k < size && made < count; k++) begin
                case ($urandom_range(19))
                    0, 1:    op = OP_NOP;
                    2:       op = OP_OUTPUT;
                    3:       op = OP_LOADI;
                    4:       op = OP_OPW_RAND();
                    default: op = OP_W'($urandom_range(7));
                endcase
                push_instr(k == 0 || $urandom_range(39) == 0, op,
                           pick_reg(wide, base, span), pick_reg(wide, base, span),
                           pick_reg(wide, base, span));
                made++;
            end
        end
    endtask

    initial begin
        logic [LEN_W-1:0] lens[7];
        lens = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd37, 13'd3, 13'd12};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 1'b0;
        pwdata   = '0;
        drive_item = '{1'b0, OP_NOP, 8'd0, 8'd0, 8'd0};
        send_idle = 28;
        recv_idle = 83;
        errors = 0;
        results_seen = 0;
        instrs_sent = 0;
        quiet_cycles = 0;
        rn_block_len = 13'd1;
        rn_fresh = '0;
        rn_pos   = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            rn_mapped[i]   = 1'b0;
            rn_has_next[i] = 1'b0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every opcode, register extremes, unknown opcodes, underflow
        write_block_len(13'd5);
        push_instr(1'b1, OP_LOAD,   8'd0,   8'd0,   8'd255);
        push_instr(1'b0, OP_STORE,  8'd0,   8'd0,   8'd255);
        push_instr(1'b0, OP_LOADI,  8'd255, 8'd255, 8'd0);
        push_instr(1'b0, OP_ADD,    8'd255, 8'd255, 8'd255);
        push_instr(1'b0, OP_SUB,    8'd0,   8'd255, 8'd0);
        push_instr(1'b0, OP_MULT,   8'd1,   8'd2,   8'd3);
        push_instr(1'b0, OP_LSHIFT, 8'd3,   8'd1,   8'd2);
        push_instr(1'b0, OP_RSHIFT, 8'd2,   8'd3,   8'd1);
        push_instr(1'b0, OP_OUTPUT, 8'd170, 8'd85,  8'd170);
        push_instr(1'b0, OP_NOP,    8'd7,   8'd7,   8'd7);
        push_instr(1'b1, OP_NOP,    8'd0,   8'd0,   8'd0);
        push_instr(1'b0, OP_STORE,  8'd9,   8'd9,   8'd9);
        for (int op = 10; op < 16; op++)
            push_instr(1'b0, OP_W'(op), 8'd9, 8'd10, 8'd9);
        push_instr(1'b1, OP_ADD,    8'd4,   8'd4,   8'd4);
        push_instr(1'b0, OP_LOAD,   8'd4,   8'd0,   8'd4);
        push_instr(1'b0, OP_NOP,    8'd4,   8'd0,   8'd4);
        drain();

        for (int p = 0; p < 7; p++) begin
            send_idle = (p < 2) ? 28 : (p < 4) ? 83 : 0;
            recv_idle = (p < 2) ? 83 : (p < 4) ? 28 : 0;
            write_block_len(lens[p]);
            random_blocks(155);
            drain();
        end

        $display("Sent %0d instructions, checked %0d results across 8 block lengths,",
                 instrs_sent, results_seen);
        $display("including clamped lengths, position underflow and unknown opcodes.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### register_rename_last_use_core.f
src/rrlu_pkg.sv
src/rrlu_front.sv
src/rrlu_back.sv
src/register_rename_last_use_core.sv
tb/tb_register_rename_last_use_core.sv
